>>> rtl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular double-ended queue: request and
// status codes, controller states, and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package cdq_pkg;

    // Default sizing
    localparam int DEPTH_DEF      = 64;
    localparam int WORD_WIDTH_DEF = 32;

    // Fixed port widths
    localparam int REQ_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int SIZE_W   = 7;
    localparam int DATA_W   = 32;
    localparam int OCC_W    = 7;
    localparam int STATUS_W = 2;

    // Request codes (code 7 is unused and does nothing)
    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_POP_BACK   = 3'd1,
        REQ_PUSH_FRONT = 3'd2,
        REQ_POP_FRONT  = 3'd3,
        REQ_READ_IDX   = 3'd4,
        REQ_RESIZE     = 3'd5,
        REQ_CLEAR      = 3'd6
    } req_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FILL,
        S_READ_ENDS,
        S_READ_IDX,
        S_RESULT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // latch the request word
        logic exec;     // carry out the request on the pointers and store
        logic fill;     // append one fill word at the back
        logic trim;     // settle count and tail to the resize target
        logic rd_ends;  // read front and back entries
        logic rd_idx;   // read indexed entry, capture front word
        logic finish;   // load the result registers
    } cdq_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_resize;
        logic fill_more;
    } cdq_stat_t;

endpackage

>>> rtl/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer for the deque: steps each request through execute, fill (resize
// only), end and indexed store reads and result load; raises the done strobe.
// ----------------------------------------------------------------------------
module cdq_ctrl
    import cdq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  cdq_stat_t stat,
    output cdq_cmd_t  cmd,
    output logic      busy,
    output logic      done
);

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    // State register and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.finish;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (start) state_next = S_EXEC;
            S_EXEC:      state_next = stat.is_resize ? S_FILL : S_READ_ENDS;
            S_FILL:      if (!stat.fill_more) state_next = S_READ_ENDS;
            S_READ_ENDS: state_next = S_READ_IDX;
            S_READ_IDX:  state_next = S_RESULT;
            S_RESULT:    state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd         = '0;
        cmd.load    = (state_reg == S_IDLE) && start;
        cmd.exec    = (state_reg == S_EXEC);
        cmd.fill    = (state_reg == S_FILL) && stat.fill_more;
        cmd.trim    = (state_reg == S_FILL) && !stat.fill_more;
        cmd.rd_ends = (state_reg == S_READ_ENDS);
        cmd.rd_idx  = (state_reg == S_READ_IDX);
        cmd.finish  = (state_reg == S_RESULT);
        busy        = (state_reg != S_IDLE);
    end

    assign done = done_reg;

endmodule

>>> rtl/cdq_dpath.sv
// ----------------------------------------------------------------------------
// cdq_dpath
// Deque datapath: head/tail/count pointers, the circular word store with one
// write and two registered read ports, and the result registers.
// ----------------------------------------------------------------------------
module cdq_dpath
    import cdq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cdq_cmd_t            cmd,
    output cdq_stat_t           stat,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [VALUE_W-1:0]  value,
    input  logic [POS_W-1:0]    position,
    input  logic [SIZE_W-1:0]   new_size,
    output logic [DATA_W-1:0]   read_data,
    output logic [DATA_W-1:0]   front_word,
    output logic [DATA_W-1:0]   back_word,
    output logic [OCC_W-1:0]    occupancy,
    output logic                is_empty,
    output logic [STATUS_W-1:0] status
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > SIZE_W) ? CW : SIZE_W;
    localparam int IW   = ((AW > POS_W) ? AW : POS_W) + 1;
    localparam int TW   = CW + 1;
    localparam logic [AW-1:0] LAST_SLOT  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    // Request latch
    logic [REQ_W-1:0]      req_reg;
    logic [WORD_WIDTH-1:0] word_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [SIZE_W-1:0]     size_reg;

    // Pointers and per-request state
    logic [AW-1:0]       head_reg, head_next;
    logic [AW-1:0]       tail_reg, tail_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       target_reg, target_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    // Store and read data
    logic [WORD_WIDTH-1:0] mem [DEPTH];
    logic [WORD_WIDTH-1:0] rd_a_reg;
    logic [WORD_WIDTH-1:0] rd_b_reg;
    logic [WORD_WIDTH-1:0] front_reg;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic                  re_a, re_b;
    logic [AW-1:0]         addr_a, addr_b;

    // Result registers
    logic [DATA_W-1:0]   read_data_reg;
    logic [DATA_W-1:0]   front_word_reg;
    logic [DATA_W-1:0]   back_word_reg;
    logic [OCC_W-1:0]    occupancy_reg;
    logic                is_empty_reg;
    logic [STATUS_W-1:0] status_out_reg;

    // Address arithmetic
    logic [AW-1:0]   head_inc, head_dec, tail_inc, tail_dec;
    logic [IW-1:0]   idx_sum;
    logic [AW-1:0]   idx_slot;
    logic [TW-1:0]   trim_sum;
    logic [AW-1:0]   trim_slot;
    logic [CMPW-1:0] size_ext;
    logic            full, empty;

    assign head_inc = (head_reg == LAST_SLOT) ? '0 : head_reg + AW'(1);
    assign head_dec = (head_reg == '0) ? LAST_SLOT : head_reg - AW'(1);
    assign tail_inc = (tail_reg == LAST_SLOT) ? '0 : tail_reg + AW'(1);
    assign tail_dec = (tail_reg == '0) ? LAST_SLOT : tail_reg - AW'(1);

    // head + pos wraps at most once whenever the position is in range
    assign idx_sum  = IW'(head_reg) + IW'(pos_reg);
    assign idx_slot = (idx_sum >= IW'(DEPTH)) ? AW'(idx_sum - IW'(DEPTH)) : AW'(idx_sum);

    // head + target, target never above DEPTH
    assign trim_sum  = TW'(head_reg) + TW'(target_reg);
    assign trim_slot = (trim_sum >= TW'(DEPTH)) ? AW'(trim_sum - TW'(DEPTH))
                                                : AW'(trim_sum);

    assign size_ext = CMPW'(size_reg);
    assign full     = (count_reg == FULL_COUNT);
    assign empty    = (count_reg == '0);

    assign stat.is_resize = (req_reg == REQ_RESIZE);
    assign stat.fill_more = (count_reg < target_reg);

    // Pointer update and write port
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        target_next = target_reg;
        status_next = status_reg;
        we          = 1'b0;
        waddr       = tail_reg;
        if (cmd.exec)
        begin
            status_next = ST_OK;
            unique case (req_reg)
                REQ_PUSH_BACK:
                begin
                    if (full)
                        status_next = ST_OVER;
                    else
                    begin
                        we         = 1'b1;
                        tail_next  = tail_inc;
                        count_next = count_reg + CW'(1);
                    end
                end
                REQ_POP_BACK:
                begin
                    if (empty)
                        status_next = ST_UNDER;
                    else
                    begin
                        tail_next  = tail_dec;
                        count_next = count_reg - CW'(1);
                    end
                end
                REQ_PUSH_FRONT:
                begin
                    if (full)
                        status_next = ST_OVER;
                    else
                    begin
                        we         = 1'b1;
                        waddr      = head_dec;
                        head_next  = head_dec;
                        count_next = count_reg + CW'(1);
                    end
                end
                REQ_POP_FRONT:
                begin
                    if (empty)
                        status_next = ST_UNDER;
                    else
                    begin
                        head_next  = head_inc;
                        count_next = count_reg - CW'(1);
                    end
                end
                REQ_READ_IDX:
                begin
                    if (CMPW'(pos_reg) >= CMPW'(count_reg))
                        status_next = ST_RANGE;
                end
                REQ_RESIZE:
                begin
                    // saturate at capacity
                    if (size_ext > CMPW'(DEPTH))
                    begin
                        target_next = FULL_COUNT;
                        status_next = ST_OVER;
                    end
                    else
                        target_next = size_ext[CW-1:0];
                end
                REQ_CLEAR:
                begin
                    head_next  = '0;
                    tail_next  = '0;
                    count_next = '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.fill)
        begin
            we         = 1'b1;
            tail_next  = tail_inc;
            count_next = count_reg + CW'(1);
        end
        else if (cmd.trim)
        begin
            count_next = target_reg;
            tail_next  = trim_slot;
        end
    end

    // Read port addressing
    always_comb
    begin
        re_a   = cmd.rd_ends || cmd.rd_idx;
        addr_a = cmd.rd_idx ? idx_slot : head_reg;
        re_b   = cmd.rd_ends;
        addr_b = tail_dec;
    end

    // Pointer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Request latch and per-request payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg  <= req_type;
            word_reg <= WORD_WIDTH'(value);
            pos_reg  <= position;
            size_reg <= new_size;
        end
        target_reg <= target_next;
        status_reg <= status_next;
        if (cmd.rd_idx)
            front_reg <= rd_a_reg;
    end

    // Word store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= word_reg;
        if (re_a)
            rd_a_reg <= mem[addr_a];
        if (re_b)
            rd_b_reg <= mem[addr_b];
    end

    // Result registers
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            read_data_reg  <= ((req_reg == REQ_READ_IDX) && (status_reg == ST_OK))
                              ? DATA_W'(rd_a_reg) : '0;
            front_word_reg <= empty ? '0 : DATA_W'(front_reg);
            back_word_reg  <= empty ? '0 : DATA_W'(rd_b_reg);
            occupancy_reg  <= OCC_W'(count_reg);
            is_empty_reg   <= empty;
            status_out_reg <= status_reg;
        end
    end

    assign read_data  = read_data_reg;
    assign front_word = front_word_reg;
    assign back_word  = back_word_reg;
    assign occupancy  = occupancy_reg;
    assign is_empty   = is_empty_reg;
    assign status     = status_out_reg;

endmodule

>>> rtl/circular_double_ended_queue.sv
// ----------------------------------------------------------------------------
// circular_double_ended_queue
// Fixed-capacity deque of data words in a circular store, with push and pop
// at both ends, indexed read, resize with fill and clear.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// word appears on the result ports for one cycle with done high, and must be
// taken then, as there is no way to hold it off. Push, pop, indexed read,
// clear and unused codes step through execute, end reads, indexed read and
// result load, then idle (done shows in the cycle the block is ready again).
// A resize adds a fill step after execute, appending fill words one per
// cycle through the store's single write port and then settling count and
// tail to the resize target. The sequence is set by the store having two
// registered read ports while each result needs three reads (front, back
// and indexed entry). Pushing onto a full deque drops the word with status
// overflow; a resize beyond capacity fills to capacity and also reports
// overflow. Store entries are never cleared and need no pass after reset.
module circular_double_ended_queue
    import cdq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [VALUE_W-1:0]  value,
    input  logic [POS_W-1:0]    position,
    input  logic [SIZE_W-1:0]   new_size,
    output logic                done,
    output logic [DATA_W-1:0]   read_data,
    output logic [DATA_W-1:0]   front_word,
    output logic [DATA_W-1:0]   back_word,
    output logic [OCC_W-1:0]    occupancy,
    output logic                is_empty,
    output logic [STATUS_W-1:0] status
);

    cdq_cmd_t  cmd;
    cdq_stat_t stat;

    cdq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    cdq_dpath #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .req_type   (req_type),
        .value      (value),
        .position   (position),
        .new_size   (new_size),
        .read_data  (read_data),
        .front_word (front_word),
        .back_word  (back_word),
        .occupancy  (occupancy),
        .is_empty   (is_empty),
        .status     (status)
    );

    // One result per request: the strobe is never held on
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    // A result only follows a request in progress
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a request in progress");

    // An accepted request makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // Underflow is reported only against an empty deque
    a_under_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_UNDER)) |-> is_empty)
        else $error("underflow reported while words are held");

endmodule
